>>> src/delayed_reuse_slot_allocator_top_assert.svh
// assertion macros for the slot allocator top level
// expects clk and rst_n in the scope of each use
`ifndef DELAYED_REUSE_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define DELAYED_REUSE_SLOT_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DRA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dra assertion failed");

// next-cycle implication, checked out of reset
`define DRA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dra assertion failed");

`endif

>>> src/dra_pkg.sv
// shared types and constants for the delayed-reuse slot allocator
// no dependencies
`default_nettype none
package dra_pkg;

  localparam int ADDR_W = 48;
  localparam int AXW    = 50;   // internal address width, room for page end overshoot
  localparam int SZW    = 14;   // effective slot size, up to 8192
  localparam int SB_W   = 13;
  localparam int TS_W   = 31;
  localparam int NOW_W  = 32;
  localparam int FLAG_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REUSE_DELAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NO_SLOT   = 2'd1;
  localparam logic [1:0] STAT_BAD_RANGE = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  localparam logic [SZW-1:0]    MIN_SLOT  = 14'd16;
  localparam logic [SB_W-1:0]   SLOT_BYTES_RST = 13'd64;
  localparam logic [AXW-1:0]    ADDR_MAX  = 50'h0_FFFF_FFFF_FFFF;
  localparam logic [FLAG_W-1:0] USED_FLAG = 32'h8000_0000;

  typedef struct packed {
    logic                op;
    logic [ADDR_W-1:0]   bound_lo;
    logic [ADDR_W-1:0]   bound_hi;
    logic [ADDR_W-1:0]   slot_address;
    logic [NOW_W-1:0]    now;
  } dra_in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [ADDR_W-1:0]   address;
  } dra_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_PREP,
    S_PAGE,
    S_SCAN,
    S_MAPCHK,
    S_CLR,
    S_MARK,
    S_FPG,
    S_FDIV,
    S_OUT
  } dra_state_t;

endpackage
`default_nettype wire

>>> src/dra_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module dra_ram #(
  parameter int W  = 32,
  parameter int D  = 4096,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem_r [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

>>> src/dra_div.sv
// restoring divider, one quotient bit per cycle, done pulses when the quotient is complete
// no dependencies
`default_nettype none
module dra_div #(
  parameter int DW = 17,
  parameter int VW = 14
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic      [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] div_r, div_nxt;
  logic [VW:0]   trial;
  logic [VW:0]   diffv;
  logic          ge;

  always_comb begin
    trial    = {rem_r, quo_r[DW-1]};
    ge       = (trial >= {1'b0, div_r});
    diffv    = trial - {1'b0, div_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diffv[VW-1:0] : trial[VW-1:0];
      quo_nxt = {quo_r[DW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

>>> src/delayed_reuse_slot_allocator_top.sv
// one item in flight at a time
// the slot flag ram gives one read per cycle, which sets the alloc scan rate
// the slot-size divider serves both the alloc slot count and the free slot index
// reset: synchronous, clears control and config; flags need no clear since mapping
// a page sweeps its flags to zero
`default_nettype none
`include "delayed_reuse_slot_allocator_top_assert.svh"
module delayed_reuse_slot_allocator_top
  import dra_pkg::*;
#(
  parameter int PAGE_BYTES         = 4096,
  parameter int MAX_PAGES          = 16,
  parameter int MAX_SLOTS_PER_PAGE = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire dra_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output dra_out_t                   out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int MSPP  = MAX_SLOTS_PER_PAGE;
  localparam int PW    = $clog2(PAGE_BYTES + 1);
  localparam int NW    = $clog2(MSPP + 1);
  localparam int MPW   = $clog2(MAX_PAGES + 1);
  localparam int DEPTH = MAX_PAGES * MSPP;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AXW-1:0] PAGE_AX = AXW'(PAGE_BYTES);

  dra_state_t           state_r, state_nxt;
  dra_in_t              in_r, in_nxt;
  dra_out_t             out_r, out_nxt;
  dra_out_t             res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [SB_W-1:0]      slot_bytes_r, slot_bytes_nxt;
  logic [TS_W-1:0]      reuse_delay_r, reuse_delay_nxt;
  logic [ADDR_W-1:0]    pool_base_r, pool_base_nxt;
  logic [MPW-1:0]       mapped_r, mapped_nxt;
  logic [SZW-1:0]       size_r, size_nxt;
  logic [NW-1:0]        n_r, n_nxt;
  logic [PW-1:0]        nsize_r, nsize_nxt;
  logic [PW-1:0]        nm1_r, nm1_nxt;
  logic [AXW-1:0]       top_start_r, top_start_nxt;
  logic [AXW-1:0]       pst_r, pst_nxt;
  logic [MPW-1:0]       pg_cnt_r, pg_cnt_nxt;
  logic [AW-1:0]        pg_base_r, pg_base_nxt;
  logic [NW-1:0]        idx_r, idx_nxt;
  logic [AXW-1:0]       cur_r, cur_nxt;
  logic                 chk_v_r, chk_v_nxt;
  logic [AW-1:0]        chk_addr_r, chk_addr_nxt;
  logic [AXW-1:0]       chk_cur_r, chk_cur_nxt;

  logic [SZW-1:0]       size_c;
  logic [SZW-1:0]       sb_round;
  logic                 between;
  logic                 cur_in;
  logic [AXW-1:0]       lo_ax, hi_ax, addr_ax;
  logic [AXW-1:0]       first, last, pend;
  logic [NW+SZW-1:0]    prod;
  logic [TS_W-1:0]      ts;
  logic                 age_ok;
  logic [MPW-1:0]       pg_dec;
  logic                 we_legal;

  logic                 div_start, div_done;
  logic [PW-1:0]        div_dividend;
  logic [PW-1:0]        div_q;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [FLAG_W-1:0]    ram_wdata, ram_rdata;

  dra_div #(.DW(PW), .VW(SZW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (size_nxt),
    .done     (div_done),
    .quotient (div_q)
  );

  dra_ram #(.W(FLAG_W), .D(DEPTH), .AW(AW)) u_flags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    sb_round = ({1'b0, slot_bytes_r} + SZW'(3)) & ~SZW'(3);
    size_c   = (sb_round < MIN_SLOT) ? MIN_SLOT : sb_round;
    between  = (in_r.bound_lo != '0) || (in_r.bound_hi != '0);
    lo_ax    = AXW'(in_r.bound_lo);
    hi_ax    = AXW'(in_r.bound_hi);
    addr_ax  = AXW'(in_r.slot_address);
    cur_in   = !between || (cur_r >= lo_ax && cur_r <= hi_ax);
    prod     = n_r * size_r;
    ts       = ram_rdata[TS_W-1:0];
    age_ok   = !ram_rdata[FLAG_W-1] && (in_r.now > {1'b0, ts})
               && ((in_r.now - {1'b0, ts}) > {1'b0, reuse_delay_r});
    pg_dec   = pg_cnt_r - MPW'(1);
    first    = pst_r - PAGE_AX;
    last     = first + AXW'(nm1_r);
    pend     = first + AXW'(nsize_r);
  end

  always_comb begin
    state_nxt       = state_r;
    in_nxt          = in_r;
    out_nxt         = out_r;
    res_nxt         = res_r;
    out_valid_nxt   = out_valid_r;
    slot_bytes_nxt  = slot_bytes_r;
    reuse_delay_nxt = reuse_delay_r;
    pool_base_nxt   = pool_base_r;
    mapped_nxt      = mapped_r;
    size_nxt        = size_r;
    n_nxt           = n_r;
    nsize_nxt       = nsize_r;
    nm1_nxt         = nm1_r;
    top_start_nxt   = top_start_r;
    pst_nxt         = pst_r;
    pg_cnt_nxt      = pg_cnt_r;
    pg_base_nxt     = pg_base_r;
    idx_nxt         = idx_r;
    cur_nxt         = cur_r;
    chk_v_nxt       = chk_v_r;
    chk_addr_nxt    = chk_addr_r;
    chk_cur_nxt     = chk_cur_r;
    div_start       = 1'b0;
    div_dividend    = PW'(PAGE_BYTES);
    ram_we          = 1'b0;
    ram_waddr       = chk_addr_r;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = pg_base_r + AW'(idx_r);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid) begin
      case (cfg_index)
        CFG_SLOT_BYTES:  slot_bytes_nxt  = cfg_data[SB_W-1:0];
        CFG_REUSE_DELAY: reuse_delay_nxt = cfg_data[TS_W-1:0];
        CFG_POOL_BASE:   pool_base_nxt   = cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          size_nxt  = size_c;
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        // slots per page = PAGE_BYTES / size, capped
        if (div_done) begin
          n_nxt     = (div_q > PW'(MSPP)) ? NW'(MSPP) : NW'(div_q);
          state_nxt = S_PREP;
        end
      end

      S_PREP: begin
        nsize_nxt     = PW'(prod);
        nm1_nxt       = PW'(prod) - PW'(size_r);
        top_start_nxt = AXW'(pool_base_r) + AXW'(mapped_r) * PAGE_AX;
        pst_nxt       = top_start_nxt;
        pg_cnt_nxt    = mapped_r;
        if (in_r.op == OP_FREE) begin
          state_nxt = S_FPG;
        end else if (in_r.bound_hi < in_r.bound_lo) begin
          res_nxt   = '{status: STAT_BAD_RANGE, address: '0};
          state_nxt = S_OUT;
        end else if (between &&
                     (in_r.bound_hi - in_r.bound_lo) < ADDR_W'(size_r)) begin
          res_nxt   = '{status: STAT_BAD_RANGE, address: '0};
          state_nxt = S_OUT;
        end else if (n_r == '0) begin
          res_nxt   = '{status: STAT_NO_SLOT, address: '0};
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_PAGE;
        end
      end

      S_PAGE: begin
        chk_v_nxt = 1'b0;
        idx_nxt   = '0;
        if (pg_cnt_r == '0) begin
          state_nxt = S_MAPCHK;
        end else begin
          pst_nxt     = first;
          pg_cnt_nxt  = pg_dec;
          pg_base_nxt = AW'(pg_dec) * AW'(MSPP);
          cur_nxt     = first;
          if (!(between && (last < lo_ax || hi_ax < first))) begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // read one flag per cycle, judge the one read last cycle
        if (chk_v_r && age_ok) begin
          ram_we    = 1'b1;
          ram_waddr = chk_addr_r;
          ram_wdata = ram_rdata | USED_FLAG;
          chk_v_nxt = 1'b0;
          res_nxt   = '{status: STAT_OK, address: chk_cur_r[ADDR_W-1:0]};
          state_nxt = S_OUT;
        end else if (idx_r < n_r) begin
          ram_re       = 1'b1;
          chk_v_nxt    = cur_in;
          chk_addr_nxt = ram_raddr;
          chk_cur_nxt  = cur_r;
          idx_nxt      = idx_r + NW'(1);
          cur_nxt      = cur_r + AXW'(size_r);
        end else begin
          chk_v_nxt = 1'b0;
          state_nxt = S_PAGE;
        end
      end

      S_MAPCHK: begin
        idx_nxt     = '0;
        cur_nxt     = top_start_r;
        chk_v_nxt   = 1'b0;
        pg_base_nxt = AW'(mapped_r) * AW'(MSPP);
        if (mapped_r >= MPW'(MAX_PAGES)) begin
          res_nxt   = '{status: STAT_NO_SLOT, address: '0};
          state_nxt = S_OUT;
        end else if ((top_start_r + AXW'(nm1_r)) > ADDR_MAX) begin
          res_nxt   = '{status: STAT_NO_SLOT, address: '0};
          state_nxt = S_OUT;
        end else if (between && ((top_start_r + AXW'(nm1_r)) < lo_ax
                                 || hi_ax < top_start_r)) begin
          res_nxt   = '{status: STAT_NO_SLOT, address: '0};
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_CLR;
        end
      end

      S_CLR: begin
        // sweep the new page to zero while looking for its first slot in range
        ram_we    = 1'b1;
        ram_waddr = pg_base_r + AW'(idx_r);
        ram_wdata = '0;
        if (!chk_v_r && idx_r < n_r && cur_in) begin
          chk_v_nxt    = 1'b1;
          chk_addr_nxt = ram_waddr;
          chk_cur_nxt  = cur_r;
        end
        idx_nxt = idx_r + NW'(1);
        cur_nxt = cur_r + AXW'(size_r);
        if (idx_r == NW'(MSPP - 1)) begin
          state_nxt = S_MARK;
        end
      end

      S_MARK: begin
        if (chk_v_r) begin
          ram_we     = 1'b1;
          ram_waddr  = chk_addr_r;
          ram_wdata  = USED_FLAG;
          mapped_nxt = mapped_r + MPW'(1);
          res_nxt    = '{status: STAT_OK, address: chk_cur_r[ADDR_W-1:0]};
        end else begin
          res_nxt = '{status: STAT_NO_SLOT, address: '0};
        end
        chk_v_nxt = 1'b0;
        state_nxt = S_OUT;
      end

      S_FPG: begin
        if (pg_cnt_r == '0) begin
          res_nxt   = '{status: STAT_NOT_FOUND, address: '0};
          state_nxt = S_OUT;
        end else begin
          pst_nxt     = first;
          pg_cnt_nxt  = pg_dec;
          pg_base_nxt = AW'(pg_dec) * AW'(MSPP);
          if (first <= addr_ax && addr_ax < pend) begin
            div_start    = 1'b1;
            div_dividend = PW'(addr_ax - first);
            state_nxt    = S_FDIV;
          end
        end
      end

      S_FDIV: begin
        if (div_done) begin
          ram_we    = 1'b1;
          ram_waddr = pg_base_r + AW'(div_q);
          ram_wdata = {1'b0, in_r.now[TS_W-1:0]};
          res_nxt   = '{status: STAT_OK, address: '0};
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      slot_bytes_r  <= SLOT_BYTES_RST;
      reuse_delay_r <= '0;
      pool_base_r   <= '0;
      mapped_r      <= '0;
      chk_v_r       <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      slot_bytes_r  <= slot_bytes_nxt;
      reuse_delay_r <= reuse_delay_nxt;
      pool_base_r   <= pool_base_nxt;
      mapped_r      <= mapped_nxt;
      chk_v_r       <= chk_v_nxt;
    end
    in_r        <= in_nxt;
    out_r       <= out_nxt;
    res_r       <= res_nxt;
    size_r      <= size_nxt;
    n_r         <= n_nxt;
    nsize_r     <= nsize_nxt;
    nm1_r       <= nm1_nxt;
    top_start_r <= top_start_nxt;
    pst_r       <= pst_nxt;
    pg_cnt_r    <= pg_cnt_nxt;
    pg_base_r   <= pg_base_nxt;
    idx_r       <= idx_nxt;
    cur_r       <= cur_nxt;
    chk_addr_r  <= chk_addr_nxt;
    chk_cur_r   <= chk_cur_nxt;
  end

  assign we_legal = (state_r == S_SCAN) || (state_r == S_CLR) ||
                    (state_r == S_MARK) || (state_r == S_FDIV);

  `DRA_ASSERT_IMP(a_mapped_bound, 1'b1, mapped_r <= MPW'(MAX_PAGES))
  `DRA_ASSERT_IMP(a_we_states, ram_we, we_legal)
  `DRA_ASSERT_IMP(a_map_step, $past(rst_n) && mapped_r != $past(mapped_r), mapped_r == $past(mapped_r) + MPW'(1))
  `DRA_ASSERT_NXT(a_accept_div, in_valid && in_ready, state_r == S_DIV)

endmodule
`default_nettype wire
